// File: sv/dcd_pkg.sv
// dcd_pkg: shared types and codes of the double click detector
// no dependencies
package dcd_pkg;

    localparam int REG_ADDR_W = 5;
    localparam int DATA_W     = 32;

    localparam logic [2:0] REG_RADIUS     = 3'd0;
    localparam logic [2:0] REG_INTERVAL   = 3'd1;
    localparam logic [2:0] REG_IGNORE     = 3'd2;
    localparam logic [2:0] REG_X_MIN      = 3'd3;
    localparam logic [2:0] REG_X_MAX      = 3'd4;
    localparam logic [2:0] REG_Y_MIN      = 3'd5;
    localparam logic [2:0] REG_Y_MAX      = 3'd6;

    localparam logic [1:0] ACT_DOWN  = 2'd0;
    localparam logic [1:0] ACT_MOVE  = 2'd1;
    localparam logic [1:0] ACT_UP    = 2'd2;

    localparam logic [1:0] PH_NONE     = 2'd0;
    localparam logic [1:0] PH_MAYBE    = 2'd1;
    localparam logic [1:0] PH_FINISHED = 2'd2;

    localparam logic [2:0] CLS_NOP    = 3'd0;
    localparam logic [2:0] CLS_IGNORE = 3'd1;
    localparam logic [2:0] CLS_CLEAR  = 3'd2;
    localparam logic [2:0] CLS_DOWN   = 3'd3;
    localparam logic [2:0] CLS_MOVEUP = 3'd4;

    typedef struct packed {
        logic [16:0]        radius;
        logic [31:0]        interval_limit;
        logic               ignore_mode;
        logic signed [15:0] region_x_min;
        logic signed [15:0] region_x_max;
        logic signed [15:0] region_y_min;
        logic signed [15:0] region_y_max;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         cls;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        event_time;
    } t_entry;

endpackage

// File: sv/dcd_regs.sv
// dcd_regs: apb configuration registers of the double click detector
// depends on dcd_pkg
module dcd_regs import dcd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius         <= 17'd30;
            r_cfg.interval_limit <= 32'd300;
            r_cfg.ignore_mode    <= 1'b0;
            r_cfg.region_x_min   <= 16'sh8000;
            r_cfg.region_x_max   <= 16'sh7fff;
            r_cfg.region_y_min   <= 16'sh8000;
            r_cfg.region_y_max   <= 16'sh7fff;
        end else if (wr_en) begin
            case (idx)
                REG_RADIUS:   r_cfg.radius         <= pwdata[16:0];
                REG_INTERVAL: r_cfg.interval_limit <= pwdata;
                REG_IGNORE:   r_cfg.ignore_mode    <= pwdata[0];
                REG_X_MIN:    r_cfg.region_x_min   <= pwdata[15:0];
                REG_X_MAX:    r_cfg.region_x_max   <= pwdata[15:0];
                REG_Y_MIN:    r_cfg.region_y_min   <= pwdata[15:0];
                REG_Y_MAX:    r_cfg.region_y_max   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_RADIUS:   prdata = {15'd0, r_cfg.radius};
            REG_INTERVAL: prdata = r_cfg.interval_limit;
            REG_IGNORE:   prdata = {31'd0, r_cfg.ignore_mode};
            REG_X_MIN:    prdata = {{16{r_cfg.region_x_min[15]}}, r_cfg.region_x_min};
            REG_X_MAX:    prdata = {{16{r_cfg.region_x_max[15]}}, r_cfg.region_x_max};
            REG_Y_MIN:    prdata = {{16{r_cfg.region_y_min[15]}}, r_cfg.region_y_min};
            REG_Y_MAX:    prdata = {{16{r_cfg.region_y_max[15]}}, r_cfg.region_y_max};
            default:      prdata = '0;
        endcase
    end

endmodule

// File: sv/dcd_front.sv
// dcd_front: classifies each incoming touch event for the back end
// depends on dcd_pkg
module dcd_front import dcd_pkg::*; (
    input  t_cfg               i_cfg,
    input  logic [1:0]         i_action,
    input  logic [3:0]         i_touch_count,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [31:0]        i_event_time,
    output t_entry             o_entry
);

    logic out_region;

    assign out_region = (i_pos_x < i_cfg.region_x_min) || (i_pos_x > i_cfg.region_x_max) ||
                        (i_pos_y < i_cfg.region_y_min) || (i_pos_y > i_cfg.region_y_max);

    always_comb begin
        o_entry.pos_x      = i_pos_x;
        o_entry.pos_y      = i_pos_y;
        o_entry.event_time = i_event_time;
        if (i_cfg.ignore_mode) begin
            o_entry.cls = CLS_IGNORE;
        end else if (i_touch_count != 4'd1 || out_region) begin
            o_entry.cls = CLS_CLEAR;
        end else if (i_action == ACT_DOWN) begin
            o_entry.cls = CLS_DOWN;
        end else if (i_action inside {ACT_MOVE, ACT_UP}) begin
            o_entry.cls = CLS_MOVEUP;
        end else begin
            o_entry.cls = CLS_NOP;
        end
    end

endmodule

// File: sv/dcd_queue.sv
// dcd_queue: two-entry queue between front and back ends
// depends on dcd_pkg
module dcd_queue import dcd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_data,
    input  logic   i_pop,
    output t_entry o_data,
    output logic   o_full,
    output logic   o_empty
);

    t_entry     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// File: sv/dcd_back.sv
// dcd_back: tap state, distance and time checks, registered result
// depends on dcd_pkg
module dcd_back import dcd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_entry             i_entry,
    input  logic               i_avail,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_trigger,
    output logic [1:0]         o_phase_now,
    output logic signed [15:0] o_tap1_x,
    output logic signed [15:0] o_tap1_y,
    output logic signed [15:0] o_tap2_x,
    output logic signed [15:0] o_tap2_y
);

    logic [1:0]         r_phase, n_phase;
    logic [15:0]        r_first_x, n_first_x;
    logic [15:0]        r_first_y, n_first_y;
    logic [31:0]        r_first_time, n_first_time;
    logic [15:0]        r_second_x, n_second_x;
    logic [15:0]        r_second_y, n_second_y;
    logic               r_out_valid;
    logic               r_trigger, n_trigger;

    logic [16:0] dx;
    logic [16:0] dy;
    logic [15:0] adx;
    logic [15:0] ady;
    logic [16:0] manhattan;
    logic [31:0] elapsed;
    logic        far;
    logic        maybe;

    assign o_pop       = i_avail && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    assign dx        = {r_first_x[15], r_first_x} - {i_entry.pos_x[15], i_entry.pos_x};
    assign dy        = {r_first_y[15], r_first_y} - {i_entry.pos_y[15], i_entry.pos_y};
    assign adx       = dx[16] ? 16'(-dx) : dx[15:0];
    assign ady       = dy[16] ? 16'(-dy) : dy[15:0];
    assign manhattan = {1'b0, adx} + {1'b0, ady};
    assign elapsed   = i_entry.event_time - r_first_time;
    assign far       = (manhattan > i_cfg.radius) || (elapsed > i_cfg.interval_limit);
    assign maybe     = (r_phase == PH_MAYBE);

    always_comb begin
        n_phase      = r_phase;
        n_first_x    = r_first_x;
        n_first_y    = r_first_y;
        n_first_time = r_first_time;
        n_second_x   = r_second_x;
        n_second_y   = r_second_y;
        n_trigger    = 1'b0;
        case (i_entry.cls)
            CLS_IGNORE, CLS_CLEAR, CLS_MOVEUP: begin
                if (i_entry.cls == CLS_CLEAR || (maybe && i_entry.cls == CLS_IGNORE) ||
                    (maybe && far && i_entry.cls == CLS_MOVEUP)) begin
                    n_phase      = PH_NONE;
                    n_first_x    = '0;
                    n_first_y    = '0;
                    n_first_time = '0;
                    n_second_x   = '0;
                    n_second_y   = '0;
                end
            end
            CLS_DOWN: begin
                if (maybe && !far) begin
                    n_second_x = i_entry.pos_x;
                    n_second_y = i_entry.pos_y;
                    n_phase    = PH_FINISHED;
                    n_trigger  = 1'b1;
                end else begin
                    n_first_x    = i_entry.pos_x;
                    n_first_y    = i_entry.pos_y;
                    n_first_time = i_entry.event_time;
                    n_phase      = PH_MAYBE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_NONE;
            r_first_x    <= '0;
            r_first_y    <= '0;
            r_first_time <= '0;
            r_second_x   <= '0;
            r_second_y   <= '0;
            r_out_valid  <= 1'b0;
            r_trigger    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase      <= n_phase;
                r_first_x    <= n_first_x;
                r_first_y    <= n_first_y;
                r_first_time <= n_first_time;
                r_second_x   <= n_second_x;
                r_second_y   <= n_second_y;
                r_trigger    <= n_trigger;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    assign o_trigger   = r_trigger;
    assign o_phase_now = r_phase;
    assign o_tap1_x    = r_first_x;
    assign o_tap1_y    = r_first_y;
    assign o_tap2_x    = r_second_x;
    assign o_tap2_y    = r_second_y;

endmodule

// File: sv/double_click_detector.sv
// double_click_detector: top level of the touch double click recognizer
// depends on dcd_pkg, dcd_regs, dcd_front, dcd_queue, dcd_back
//
// input channel: one touch event per transaction (i_in_valid / o_in_ready)
// output channel: one result per event (o_out_valid / i_out_ready), carrying
// the trigger flag, phase after the event and the held tap coordinates
// config: apb write in setup and access cycles, pready tied high, reads
// return the register value; write only while no event is in flight
// the front end classifies an event in the accept cycle and pushes it into
// a two-entry queue; the back end pops one entry a cycle when the output
// register is free or being taken, updates the tap state and loads that register
// path: the queue registers an accepted event, the back end pops it and
// loads the result into the output register, where it waits for i_out_ready
// throughput: one event per cycle while the output register drains, set by
// the state update in the back end
// stall: while the receiver holds i_out_ready low the result stays put and
// the queue absorbs up to two more events before o_in_ready drops
// reset: synchronous active low, clears phase and taps, empties the queue
// and loads the register defaults
module double_click_detector import dcd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_action,
    input  logic [3:0]            i_touch_count,
    input  logic signed [15:0]    i_pos_x,
    input  logic signed [15:0]    i_pos_y,
    input  logic [31:0]           i_event_time,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_trigger,
    output logic [1:0]            o_phase_now,
    output logic signed [15:0]    o_tap1_x,
    output logic signed [15:0]    o_tap1_y,
    output logic signed [15:0]    o_tap2_x,
    output logic signed [15:0]    o_tap2_y
);

    t_cfg   cfg;
    t_entry front_entry;
    t_entry queue_entry;
    logic   q_full;
    logic   q_empty;
    logic   q_push;
    logic   q_pop;

    assign o_in_ready = !q_full;
    assign q_push     = i_in_valid && !q_full;

    dcd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dcd_front u_front (
        .i_cfg         (cfg),
        .i_action      (i_action),
        .i_touch_count (i_touch_count),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_event_time  (i_event_time),
        .o_entry       (front_entry)
    );

    dcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_entry),
        .i_pop   (q_pop),
        .o_data  (queue_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    dcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_entry     (queue_entry),
        .i_avail     (!q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_trigger   (o_trigger),
        .o_phase_now (o_phase_now),
        .o_tap1_x    (o_tap1_x),
        .o_tap1_y    (o_tap1_y),
        .o_tap2_x    (o_tap2_x),
        .o_tap2_y    (o_tap2_y)
    );

endmodule

// File: sim/double_click_detector_tb.sv
// double_click_detector_tb: self-checking testbench of the double click detector
// drives touch events and apb register writes, predicts every result and compares it
// depends on dcd_pkg and double_click_detector
module double_click_detector_tb import dcd_pkg::*; ();

    localparam logic [1:0] ACT_OTHER   = 2'd3;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         NUM_PLANS   = 8;

    typedef struct packed {
        logic               trig;
        logic [1:0]         phase;
        logic signed [15:0] tap1_x;
        logic signed [15:0] tap1_y;
        logic signed [15:0] tap2_x;
        logic signed [15:0] tap2_y;
    } t_click_result;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         count;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        stamp;
    } t_touch_event;

    typedef enum logic {ROW_EVENT, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind     kind;
        logic [2:0]    reg_idx;
        logic [31:0]   reg_val;
        t_touch_event  ev;
        bit            typed;
        t_click_result want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [REG_ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_action = '0;
    logic [3:0]            i_touch_count = '0;
    logic signed [15:0]    i_pos_x = '0;
    logic signed [15:0]    i_pos_y = '0;
    logic [31:0]           i_event_time = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_trigger;
    logic [1:0]            o_phase_now;
    logic signed [15:0]    o_tap1_x;
    logic signed [15:0]    o_tap1_y;
    logic signed [15:0]    o_tap2_x;
    logic signed [15:0]    o_tap2_y;

    double_click_detector dut (.*);

    // predictor state and register copy
    t_cfg               cfg_now;
    logic [1:0]         pred_phase;
    logic signed [15:0] first_x, first_y, second_x, second_y;
    logic [31:0]        first_time;

    t_click_result awaited_clicks[$];
    int            mismatches = 0;
    int            events_sent = 0;
    int            cycle_count = 0;
    int            calm_left = 0;
    int            ready_left = 0;
    logic [31:0]   tick;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_taps();
        pred_phase = PH_NONE;
        first_x    = '0;
        first_y    = '0;
        first_time = '0;
        second_x   = '0;
        second_y   = '0;
    endfunction

    function automatic t_click_result predict_click(t_touch_event e);
        t_click_result r;
        longint        dx, dy, manhattan;
        logic [31:0]   elapsed;
        logic          far;
        logic          trig;
        dx        = longint'(first_x) - longint'(e.x);
        dy        = longint'(first_y) - longint'(e.y);
        manhattan = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
        elapsed   = e.stamp - first_time;
        far       = (manhattan > longint'(cfg_now.radius)) ||
                    (elapsed > cfg_now.interval_limit);
        trig      = 1'b0;
        if (cfg_now.ignore_mode) begin
            if (pred_phase == PH_MAYBE) clear_taps();
        end else if (e.count != 4'd1) begin
            clear_taps();
        end else if (e.x < cfg_now.region_x_min || e.x > cfg_now.region_x_max ||
                     e.y < cfg_now.region_y_min || e.y > cfg_now.region_y_max) begin
            clear_taps();
        end else if (e.action == ACT_DOWN) begin
            if (pred_phase == PH_MAYBE && !far) begin
                second_x   = e.x;
                second_y   = e.y;
                pred_phase = PH_FINISHED;
                trig       = 1'b1;
            end else begin
                first_x    = e.x;
                first_y    = e.y;
                first_time = e.stamp;
                pred_phase = PH_MAYBE;
            end
        end else if (e.action == ACT_MOVE || e.action == ACT_UP) begin
            if (pred_phase == PH_MAYBE && far) clear_taps();
        end
        r.trig   = trig;
        r.phase  = pred_phase;
        r.tap1_x = first_x;
        r.tap1_y = first_y;
        r.tap2_x = second_x;
        r.tap2_y = second_y;
        return r;
    endfunction

    function automatic t_touch_event mk(int a, int c, int x, int y, logic [31:0] t);
        t_touch_event e;
        e.action = 2'(a);
        e.count  = 4'(c);
        e.x      = 16'(x);
        e.y      = 16'(y);
        e.stamp  = t;
        return e;
    endfunction

    function automatic t_stim_row ev_row(int a, int c, int x, int y, logic [31:0] t);
        t_stim_row r;
        r.kind    = ROW_EVENT;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.ev      = mk(a, c, x, y, t);
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic t_stim_row ck_row(int a, int c, int x, int y, logic [31:0] t,
                                         logic trig, logic [1:0] ph,
                                         int t1x, int t1y, int t2x, int t2y);
        t_stim_row r;
        r = ev_row(a, c, x, y, t);
        r.typed       = 1'b1;
        r.want.trig   = trig;
        r.want.phase  = ph;
        r.want.tap1_x = 16'(t1x);
        r.want.tap1_y = 16'(t1y);
        r.want.tap2_x = 16'(t2x);
        r.want.tap2_y = 16'(t2y);
        return r;
    endfunction

    function automatic t_stim_row cfg_row(logic [2:0] idx, int val);
        t_stim_row r;
        r = ev_row(ACT_OTHER, 0, 0, 0, '0);
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = 32'(val);
        return r;
    endfunction

    function automatic t_cfg setting(int r, logic [31:0] lim, bit ign,
                                     int xl, int xh, int yl, int yh);
        t_cfg c;
        c.radius         = 17'(r);
        c.interval_limit = lim;
        c.ignore_mode    = ign;
        c.region_x_min   = 16'(xl);
        c.region_x_max   = 16'(xh);
        c.region_y_min   = 16'(yl);
        c.region_y_max   = 16'(yh);
        return c;
    endfunction

    function automatic int clamp_to(int v, int lo, int hi);
        if (lo > hi) begin
            lo = -32768;
            hi = 32767;
        end
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int pick_in(int lo, int hi);
        if (lo > hi) return int'($urandom_range(0, 65535)) - 32768;
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return hi;
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    function automatic int next_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        case ($urandom_range(0, 19))
            0:             begin calm_left = $urandom_range(10, 60); return 0; end
            1:             return $urandom_range(8, 30);
            2, 3, 4, 5, 6: return $urandom_range(1, 3);
            default:       return 0;
        endcase
    endfunction

    // one input transaction; valid is left high so back-to-back events need no gap
    task automatic send_event(t_touch_event e, bit typed, t_click_result want);
        int            gap;
        t_click_result got;
        gap = next_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= e.action;
        i_touch_count <= e.count;
        i_pos_x       <= e.x;
        i_pos_y       <= e.y;
        i_event_time  <= e.stamp;
        do @(posedge i_clk); while (!o_in_ready);
        got = predict_click(e);
        awaited_clicks.push_back(typed ? want : got);
        events_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (awaited_clicks.size() != 0) @(posedge i_clk);
    endtask

    // apb write followed by a read back of the same register
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        logic [31:0] mask;
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mask = '0;
        case (idx)
            REG_RADIUS:   begin cfg_now.radius = val[16:0];       mask = 32'h1_FFFF; end
            REG_INTERVAL: begin cfg_now.interval_limit = val;      mask = 32'hFFFF_FFFF; end
            REG_IGNORE:   begin cfg_now.ignore_mode = val[0];      mask = 32'h1; end
            REG_X_MIN:    begin cfg_now.region_x_min = val[15:0];  mask = 32'hFFFF; end
            REG_X_MAX:    begin cfg_now.region_x_max = val[15:0];  mask = 32'hFFFF; end
            REG_Y_MIN:    begin cfg_now.region_y_min = val[15:0];  mask = 32'hFFFF; end
            REG_Y_MAX:    begin cfg_now.region_y_max = val[15:0];  mask = 32'hFFFF; end
            default:      mask = '0;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        if ((rd & mask) !== (val & mask)) begin
            $error("register %0d read back: expected %0h, actual %0h", idx, val & mask,
                   rd & mask);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // well-formed tap pair around the radius and interval bounds
    task automatic play_gesture();
        int          x0, y0, x, y, moves, reach, dx, dy;
        logic [31:0] span, lim;
        lim = cfg_now.interval_limit;
        case ($urandom_range(0, 4))
            0:       span = lim;
            1:       span = lim + 1;
            2:       span = (lim != 0) ? lim - 1 : '0;
            default: span = $urandom_range(0, lim);
        endcase
        x0    = pick_in(cfg_now.region_x_min, cfg_now.region_x_max);
        y0    = pick_in(cfg_now.region_y_min, cfg_now.region_y_max);
        moves = $urandom_range(0, 3);
        send_event(mk(ACT_DOWN, 1, x0, y0, tick), 1'b0, '0);
        for (int m = 0; m <= moves; m++) begin
            case ($urandom_range(0, 4))
                0:       reach = cfg_now.radius;
                1:       reach = cfg_now.radius + 1;
                2:       reach = (cfg_now.radius != 0) ? cfg_now.radius - 1 : 0;
                3:       reach = $urandom_range(0, 3);
                default: reach = $urandom_range(0, cfg_now.radius);
            endcase
            dx = $urandom_range(0, reach);
            dy = reach - dx;
            if ($urandom_range(0, 1) != 0) dx = -dx;
            if ($urandom_range(0, 1) != 0) dy = -dy;
            x = clamp_to(x0 + dx, cfg_now.region_x_min, cfg_now.region_x_max);
            y = clamp_to(y0 + dy, cfg_now.region_y_min, cfg_now.region_y_max);
            if (m == moves) begin
                send_event(mk(ACT_DOWN, 1, x, y, tick + span), 1'b0, '0);
            end else begin
                send_event(mk(($urandom_range(0, 1) != 0) ? ACT_MOVE : ACT_UP, 1, x, y,
                              tick + (($urandom_range(0, 3) == 0) ? span
                                                                  : $urandom_range(0, span))),
                           1'b0, '0);
            end
        end
        if ($urandom_range(0, 3) == 0)
            send_event(mk(ACT_DOWN, 1, x, y, tick + span + $urandom_range(0, 40)), 1'b0, '0);
        if ($urandom_range(0, 19) == 0) tick = $urandom;
        else tick = tick + span + $urandom_range(1, 2000);
    endtask

    always @(posedge i_clk) begin
        if (ready_left > 0) begin
            ready_left--;
        end else begin
            case ($urandom_range(0, 19))
                0:             begin i_out_ready <= 1'b0; ready_left = $urandom_range(10, 40); end
                1:             begin i_out_ready <= 1'b1; ready_left = $urandom_range(20, 80); end
                2, 3, 4, 5, 6: begin i_out_ready <= 1'b0; ready_left = $urandom_range(0, 3); end
                default:       begin i_out_ready <= 1'b1; ready_left = $urandom_range(0, 4); end
            endcase
        end
    end

    function automatic void compare_field(string nm, logic signed [31:0] want,
                                          logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", nm, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_click_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_clicks.size() == 0) begin
                $error("result transaction with no event outstanding");
                mismatches++;
            end else begin
                want = awaited_clicks.pop_front();
                compare_field("trigger",   want.trig,   o_trigger);
                compare_field("phase_now", want.phase,  o_phase_now);
                compare_field("tap1_x",    want.tap1_x, o_tap1_x);
                compare_field("tap1_y",    want.tap1_y, o_tap1_y);
                compare_field("tap2_x",    want.tap2_x, o_tap2_x);
                compare_field("tap2_y",    want.tap2_y, o_tap2_y);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_stim_row directed[$];
        t_cfg      plan[NUM_PLANS];
        t_cfg      c;
        int        budget_end;
        cfg_now = setting(30, 32'd300, 1'b0, -32768, 32767, -32768, 32767);
        clear_taps();
        tick = $urandom;

        // default radius 30, interval 300, full region
        directed.push_back(ck_row(ACT_DOWN, 1, 100, 200, 1000, 0, PH_MAYBE, 100, 200, 0, 0));
        directed.push_back(ck_row(ACT_DOWN, 1, 110, 215, 1100,
                                  1, PH_FINISHED, 100, 200, 110, 215));
        directed.push_back(ev_row(ACT_MOVE, 1, 500, 500, 9000));
        directed.push_back(ev_row(ACT_DOWN, 1, 0, 0, 2000));
        directed.push_back(ev_row(ACT_DOWN, 1, 20, 10, 2300));
        directed.push_back(ev_row(ACT_DOWN, 1, -32768, -32768, 0));
        directed.push_back(ev_row(ACT_DOWN, 1, -32737, -32768, 5));
        directed.push_back(ev_row(ACT_DOWN, 1, -32737, -32768, 306));
        directed.push_back(ev_row(ACT_UP, 1, 32767, 32767, 310));
        directed.push_back(ev_row(ACT_DOWN, 1, 32767, 32767, 32'hFFFF_FF00));
        directed.push_back(ev_row(ACT_MOVE, 1, 32760, 32767, 32'h10));
        directed.push_back(ev_row(ACT_UP, 1, 32767, 32760, 32'h20));
        directed.push_back(ev_row(ACT_DOWN, 1, 32767, 32767, 32'h12C));
        directed.push_back(ev_row(ACT_OTHER, 1, 0, 0, 0));
        directed.push_back(ck_row(ACT_DOWN, 0, 1, 1, 7, 0, PH_NONE, 0, 0, 0, 0));
        directed.push_back(ev_row(ACT_DOWN, 1, 5, 5, 100));
        directed.push_back(ck_row(ACT_MOVE, 15, 5, 5, 100, 0, PH_NONE, 0, 0, 0, 0));
        directed.push_back(ev_row(ACT_DOWN, 1, 5, 5, 100));
        directed.push_back(ev_row(ACT_MOVE, 1, 5, 5, 500));
        directed.push_back(ev_row(ACT_MOVE, 1, 5, 5, 600));
        // restricted region
        directed.push_back(cfg_row(REG_X_MIN, -100));
        directed.push_back(cfg_row(REG_X_MAX, 100));
        directed.push_back(cfg_row(REG_Y_MIN, -50));
        directed.push_back(cfg_row(REG_Y_MAX, 50));
        directed.push_back(ev_row(ACT_DOWN, 1, -100, 50, 0));
        directed.push_back(ck_row(ACT_DOWN, 1, 101, 0, 10, 0, PH_NONE, 0, 0, 0, 0));
        directed.push_back(ev_row(ACT_DOWN, 1, 100, -50, 20));
        directed.push_back(ck_row(ACT_OTHER, 2, 0, 0, 30, 0, PH_NONE, 0, 0, 0, 0));
        // ignore mode drops a pending tap
        directed.push_back(ev_row(ACT_DOWN, 1, 0, 0, 40));
        directed.push_back(cfg_row(REG_IGNORE, 1));
        directed.push_back(ck_row(ACT_DOWN, 1, 1, 1, 41, 0, PH_NONE, 0, 0, 0, 0));
        directed.push_back(ev_row(ACT_DOWN, 1, 0, 0, 42));
        // empty region clears everything
        directed.push_back(cfg_row(REG_IGNORE, 0));
        directed.push_back(cfg_row(REG_X_MIN, 10));
        directed.push_back(cfg_row(REG_X_MAX, 9));
        directed.push_back(ck_row(ACT_DOWN, 1, 9, 0, 50, 0, PH_NONE, 0, 0, 0, 0));

        plan[0] = setting(30, 32'd300, 1'b0, -32768, 32767, -32768, 32767);
        plan[1] = setting(0, 32'd0, 1'b0, -32768, 32767, -32768, 32767);
        plan[2] = setting(131070, 32'hFFFF_FFFF, 1'b0, -32768, 32767, -32768, 32767);
        plan[3] = setting(10, 32'd50, 1'b0, -20, 20, 0, 40);
        plan[4] = setting(1000, 32'd5000, 1'b0, -32768, -30000, 30000, 32767);
        plan[5] = setting(30, 32'd300, 1'b0, -32768, 32767, 1, 0);
        plan[6] = setting(100, 32'd1000, 1'b1, -32768, 32767, -32768, 32767);
        plan[7] = plan[0];

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_REG) begin
                wait_idle();
                write_reg(directed[i].reg_idx, directed[i].reg_val);
            end else begin
                send_event(directed[i].ev, directed[i].typed, directed[i].want);
            end
        end

        for (int k = 0; k < NUM_PLANS; k++) begin
            c = plan[k];
            if (k == NUM_PLANS - 1) begin
                c = setting($urandom_range(0, 131070),
                            ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1000) : $urandom,
                            1'b0, 0, 0, 0, 0);
                c.region_x_min = 16'($urandom_range(0, 65535));
                c.region_x_max = 16'($urandom_range(0, 65535));
                c.region_y_min = 16'($urandom_range(0, 65535));
                c.region_y_max = 16'($urandom_range(0, 65535));
                if (c.region_x_min > c.region_x_max) {c.region_x_min, c.region_x_max} =
                    {c.region_x_max, c.region_x_min};
                if (c.region_y_min > c.region_y_max) {c.region_y_min, c.region_y_max} =
                    {c.region_y_max, c.region_y_min};
            end
            wait_idle();
            write_reg(REG_RADIUS,   32'(c.radius));
            write_reg(REG_INTERVAL, c.interval_limit);
            write_reg(REG_IGNORE,   32'(c.ignore_mode));
            write_reg(REG_X_MIN,    32'(c.region_x_min));
            write_reg(REG_X_MAX,    32'(c.region_x_max));
            write_reg(REG_Y_MIN,    32'(c.region_y_min));
            write_reg(REG_Y_MAX,    32'(c.region_y_max));
            budget_end = events_sent + ((k == 5 || k == 6) ? 60 : 285);
            while (events_sent < budget_end) begin
                if ($urandom_range(0, 9) < 7) begin
                    play_gesture();
                end else begin
                    send_event(mk($urandom_range(0, 3),
                                  ($urandom_range(0, 2) != 0) ? 1 : $urandom_range(0, 15),
                                  ($urandom_range(0, 1) != 0)
                                      ? int'($urandom_range(0, 65535))
                                      : pick_in(cfg_now.region_x_min, cfg_now.region_x_max),
                                  ($urandom_range(0, 1) != 0)
                                      ? int'($urandom_range(0, 65535))
                                      : pick_in(cfg_now.region_y_min, cfg_now.region_y_max),
                                  ($urandom_range(0, 1) != 0)
                                      ? tick + $urandom_range(0, 400) : $urandom),
                               1'b0, '0);
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (awaited_clicks.size() != 0) begin
            $error("%0d result transactions never arrived", awaited_clicks.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/dcd_pkg.sv
sv/dcd_regs.sv
sv/dcd_front.sv
sv/dcd_queue.sv
sv/dcd_back.sv
sv/double_click_detector.sv
sim/double_click_detector_tb.sv
